// ===== rtl/nibble_4b5b_byte_codec_defines.svh =====
// Assertion macros shared by the codec RTL.
`ifndef NIBBLE_4B5B_BYTE_CODEC_DEFINES_SVH
`define NIBBLE_4B5B_BYTE_CODEC_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NBC_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("codec check failed: same-cycle rule");

// Next-cycle implication, checked outside reset.
`define NBC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("codec check failed: next-cycle rule");

`endif

// ===== rtl/nbc_pkg.sv =====
// Types, constants and code tables of the 4B5B byte codec.
package nbc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StoreW  = 16;
  localparam int unsigned FillW   = 5;
  localparam int unsigned GroupW  = 5;
  localparam int unsigned QDepth  = 3;

  // Direction register values.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Bits added per word in each direction, the fill limit, the decode threshold and the encode thresholds.
  localparam logic [FillW-1:0] EncBits  = 5'd10;
  localparam logic [FillW-1:0] DecBits  = 5'd8;
  localparam logic [FillW-1:0] FillMax  = 5'd16;
  localparam logic [FillW-1:0] DecNeed  = 5'd10;
  localparam logic [FillW-1:0] EncEmit1 = 5'd6;
  localparam logic [FillW-1:0] EncEmit2 = 5'd14;

  // One result word waiting in the output queue.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             err;
    logic             last;
  } result_t;

  // Data nibble to its 5-bit line code.
  function automatic logic [GroupW-1:0] enc_nibble(input logic [3:0] nib);
    logic [GroupW-1:0] code;
    case (nib)
      4'h0: code = 5'b11110;
      4'h1: code = 5'b01001;
      4'h2: code = 5'b10100;
      4'h3: code = 5'b10101;
      4'h4: code = 5'b01010;
      4'h5: code = 5'b01011;
      4'h6: code = 5'b01110;
      4'h7: code = 5'b01111;
      4'h8: code = 5'b10010;
      4'h9: code = 5'b10011;
      4'hA: code = 5'b10110;
      4'hB: code = 5'b10111;
      4'hC: code = 5'b11010;
      4'hD: code = 5'b11011;
      4'hE: code = 5'b11100;
      4'hF: code = 5'b11101;
      default: code = 5'b11110;
    endcase
    return code;
  endfunction

  // Line code back to its nibble; bit 4 set means the group is no data code.
  function automatic logic [4:0] dec_group(input logic [GroupW-1:0] grp);
    logic [4:0] res;
    case (grp)
      5'b11110: res = 5'h00;
      5'b01001: res = 5'h01;
      5'b10100: res = 5'h02;
      5'b10101: res = 5'h03;
      5'b01010: res = 5'h04;
      5'b01011: res = 5'h05;
      5'b01110: res = 5'h06;
      5'b01111: res = 5'h07;
      5'b10010: res = 5'h08;
      5'b10011: res = 5'h09;
      5'b10110: res = 5'h0A;
      5'b10111: res = 5'h0B;
      5'b11010: res = 5'h0C;
      5'b11011: res = 5'h0D;
      5'b11100: res = 5'h0E;
      5'b11101: res = 5'h0F;
      default:  res = 5'h10;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/nibble_4b5b_byte_codec.sv =====
// 4B5B byte codec: bit accumulator, result logic and output queue.
//
// Usage: words enter on in_valid/in_ready with data_byte and flush; results
// leave on out_valid/out_ready with out_byte, code_error and last. The
// direction register (cfg_write/cfg_data) picks encode (0) or decode (1)
// and must be written only while the block is idle, which the block does
// not enforce. Each input word updates the 16-bit bit store in the cycle
// it is accepted and drops its zero, one or two result words into a
// three-entry output queue, whose entries are registered.
// Throughput: in_ready is high while the queue holds at most one word, so
// while the receiver takes results a word is taken every cycle when it
// yields at most one result. Four encoded words make five stream bytes,
// so the single output port limits the sustained encode rate; decoding
// takes one word per cycle while the receiver keeps up. last marks the
// final result of each input word.
// Reset clears the direction, the bit store, the fill count and the queue count.
// When the receiver stalls, the queue fills and in_ready drops once two
// results wait; nothing is lost and the output word holds until taken.
`include "nibble_4b5b_byte_codec_defines.svh"

module nibble_4b5b_byte_codec
  import nbc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [ByteW-1:0] data_byte,
  input  logic             flush,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_byte,
  output logic             code_error,
  output logic             last
);

  logic              direction;
  logic [StoreW-1:0] bit_store, bit_store_next;
  logic [FillW-1:0]  fill_count, fill_count_next;
  result_t           q [QDepth];
  result_t           q_next [QDepth];
  logic [1:0]        cnt, cnt_next;

  logic              accept, pop;
  logic              enc_step, dec_step;
  logic [9:0]        app_val;
  logic [FillW-1:0]  app_len;
  logic [31:0]       app_wide;
  logic [StoreW-1:0] store_a;
  logic [FillW-1:0]  fill_a;
  logic [4:0]        lo_dec, hi_dec;
  result_t           res0, res1;
  logic [1:0]        n_res;

  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign in_ready  = (cnt <= 2'd1);
  assign out_valid = (cnt != 2'd0);
  assign out_byte   = q[0].data;
  assign code_error = q[0].err;
  assign last       = q[0].last;
  assign enc_step   = accept && !flush && direction == DirEncode;
  assign dec_step   = accept && !flush && direction == DirDecode;

  // Direction register.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DirEncode;
    end else if (cfg_write) begin
      direction <= cfg_data;
    end
  end

  // Append the new bits at the current fill, saturating the count at 16.
  always_comb begin
    if (direction == DirEncode) begin
      app_val = {enc_nibble(data_byte[7:4]), enc_nibble(data_byte[3:0])};
      app_len = EncBits;
    end else begin
      app_val = {2'b00, data_byte};
      app_len = DecBits;
    end
    app_wide = {22'd0, app_val} << fill_count[3:0];
    store_a  = fill_count[4] ? bit_store : (bit_store | app_wide[StoreW-1:0]);
    fill_a   = (fill_count + app_len > FillMax) ? FillMax : fill_count + app_len;
    lo_dec   = dec_group(store_a[4:0]);
    hi_dec   = dec_group(store_a[9:5]);
  end

  // Results and next state for the word on the input.
  always_comb begin
    res0            = '0;
    res1            = '0;
    n_res           = 2'd0;
    bit_store_next  = bit_store;
    fill_count_next = fill_count;
    if (flush) begin
      bit_store_next  = '0;
      fill_count_next = '0;
      if (direction == DirEncode && fill_count != '0) begin
        n_res     = 2'd1;
        res0.data = bit_store[7:0];
        res0.last = 1'b1;
      end
    end else if (direction == DirEncode) begin
      res0.data = store_a[7:0];
      res1.data = store_a[15:8];
      if (fill_a > EncEmit2) begin
        n_res           = 2'd2;
        res1.last       = 1'b1;
        bit_store_next  = '0;
        fill_count_next = fill_a - 5'd16;
      end else if (fill_a > EncEmit1) begin
        n_res           = 2'd1;
        res0.last       = 1'b1;
        bit_store_next  = {8'd0, store_a[15:8]};
        fill_count_next = fill_a - 5'd8;
      end else begin
        bit_store_next  = store_a;
        fill_count_next = fill_a;
      end
    end else begin
      bit_store_next  = store_a;
      fill_count_next = fill_a;
      if (fill_a >= DecNeed) begin
        n_res           = 2'd1;
        res0.data       = {hi_dec[3:0] & {4{~hi_dec[4]}}, lo_dec[3:0] & {4{~lo_dec[4]}}};
        res0.err        = lo_dec[4] | hi_dec[4];
        res0.last       = 1'b1;
        bit_store_next  = {10'd0, store_a[15:10]};
        fill_count_next = fill_a - DecNeed;
      end
    end
  end

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store  <= '0;
      fill_count <= '0;
    end else if (accept) begin
      bit_store  <= bit_store_next;
      fill_count <= fill_count_next;
    end
  end

  // Output queue: shift out on pop, then place new results behind the rest.
  always_comb begin
    logic [1:0] base_cnt;
    base_cnt = cnt;
    for (int i = 0; i < QDepth; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_next[i] = q[i+1];
      end
      base_cnt = cnt - 2'd1;
    end
    cnt_next = base_cnt;
    if (accept) begin
      for (int i = 0; i < QDepth; i++) begin
        if (n_res != 2'd0 && base_cnt == 2'(i)) begin
          q_next[i] = res0;
        end
        if (n_res == 2'd2 && 2'(base_cnt + 2'd1) == 2'(i)) begin
          q_next[i] = res1;
        end
      end
      cnt_next = base_cnt + n_res;
    end
  end

  // Queue count is control state; the entries hold payload only.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q[i] <= q_next[i];
    end
  end

  // The fill count only ever holds an even number of bits up to 16.
  `NBC_ASSERT_NOW(a_fill_even, clk, rst, 1'b1, fill_count[0] == 1'b0 && fill_count <= FillMax)
  // Encoding leaves at most six bits behind.
  `NBC_ASSERT_NEXT(a_enc_fill, clk, rst, enc_step, fill_count <= EncEmit1)
  // Decoding never keeps a full ten-bit pair undecoded.
  `NBC_ASSERT_NEXT(a_dec_fill, clk, rst, dec_step, fill_count < DecNeed)
  // A flush empties the accumulator.
  `NBC_ASSERT_NEXT(a_flush_clear, clk, rst, accept && flush, fill_count == '0 && bit_store == '0)

endmodule
